### design/bfha_pkg.sv
// Shared types and constants of the best-fit heap allocator.
`default_nettype none
package bfha_pkg;
    localparam int unsigned HEAP_BYTES    = 65536;
    localparam int unsigned FREE_ENTRIES  = 64;
    localparam int unsigned GRANT_ENTRIES = 64;
    localparam int unsigned CNT_W = $clog2((FREE_ENTRIES > GRANT_ENTRIES) ?
                                           FREE_ENTRIES : GRANT_ENTRIES);

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_FIT    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [1:0] REG_HEAP_BYTES = 2'd0;
    localparam logic [1:0] REG_ALIGN_LOG2 = 2'd1;

    localparam logic CMD_ALLOC = 1'b0;

    typedef struct packed {
        logic        valid;
        logic [15:0] start;
        logic [16:0] len;
        logic [31:0] stamp;
    } free_cell_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] start;
        logic [16:0] len;
    } grant_cell_t;
endpackage
`default_nettype wire

### design/best_fit_heap_allocator.sv
// Top level: best-fit heap allocator over two rotating chains of cells.
//
//  channel | dir | handshake              | payload
//  s_      | in  | s_tvalid / s_tready    | tuser: cmd; tdata: request_bytes, block_offset
//  m_      | out | m_tvalid / m_tready    | tdata: status, grant_offset, grant_bytes, used
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An allocate scans the free chain, inserts into the grant chain and updates the free chain;
// a free finds the grant, scans and updates the free chain and deletes the grant; errors end
// early. Each pass rotates one chain a full turn past the head cell, where the sequencer reads
// and rewrites it. Reset and writes to REG_HEAP_BYTES or REG_ALIGN_LOG2 rebuild the chains.
// The result register holds until taken; a following result waits in S_OUT for it to drain.
`default_nettype none
module best_fit_heap_allocator
    import bfha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // request_bytes[16:0], block_offset[32:17]
    input  wire logic        s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // status[2:0], grant_offset[18:3],
                                        // grant_bytes[35:19], used_bytes[52:36]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);
    typedef enum logic [3:0] {
        S_LOAD, S_IDLE, S_A_FSCAN, S_A_GINS, S_A_FUPD,
        S_F_GFIND, S_F_FSCAN, S_F_FUPD, S_F_GDEL, S_OUT
    } state_t;

    localparam logic [CNT_W-1:0] F_LAST = CNT_W'(FREE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] G_LAST = CNT_W'(GRANT_ENTRIES - 1);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [16:0] heap_reg, heap_next;
    logic [2:0]  align_reg, align_next;
    logic [17:0] size_reg, size_next;
    logic [15:0] off_reg, off_next;
    logic [31:0] ic_reg, ic_next;
    logic [16:0] used_reg, used_next;
    logic        bf_reg, bf_next;
    logic [16:0] bl_reg, bl_next;
    logic [31:0] bs_reg, bs_next;
    logic [15:0] bst_reg, bst_next;
    logic        ins_reg, ins_next;
    logic        pf_reg, pf_next;
    logic [15:0] ps_reg, ps_next;
    logic [16:0] pl_reg, pl_next;
    logic        nf_reg, nf_next;
    logic [16:0] nl_reg, nl_next;
    logic        ef_reg, ef_next;
    logic        gf_reg, gf_next;
    logic [16:0] gs_reg, gs_next;
    logic [2:0]  rs_reg, rs_next;
    logic [15:0] ro_reg, ro_next;
    logic [16:0] rb_reg, rb_next;
    logic        mv_reg, mv_next;
    logic [55:0] md_reg, md_next;

    free_cell_t  fq [FREE_ENTRIES];
    free_cell_t  fd [FREE_ENTRIES];
    grant_cell_t gq [GRANT_ENTRIES];
    grant_cell_t gd [GRANT_ENTRIES];
    free_cell_t  f_tail, f_init;
    grant_cell_t g_tail;
    logic        f_shift, g_shift, load_en;

    logic [16:0] amask, hcap, hsize;
    logic [17:0] req_round;
    logic        f_last, g_last;
    free_cell_t  fh, merged;
    grant_cell_t gh;
    logic        cand_bf;
    logic        is_prev, is_next;

    always_comb begin
        unique case (align_reg)
            3'd3:    amask = 17'd7;
            3'd4:    amask = 17'd15;
            3'd5:    amask = 17'd31;
            default: amask = 17'd3;
        endcase
        hcap   = (heap_reg > 17'(HEAP_BYTES)) ? 17'(HEAP_BYTES) : heap_reg;
        hsize  = hcap & ~amask;
        f_init = '{valid: (hsize != 17'd0), start: 16'd0, len: hsize, stamp: 32'd0};
        req_round = ({1'b0, s_tdata[16:0]} + {1'b0, amask}) & ~{1'b0, amask};
    end

    assign fh = fq[0];
    assign gh = gq[0];
    assign f_last = (cnt_reg == F_LAST);
    assign g_last = (cnt_reg == G_LAST);
    assign is_prev = fh.valid && (({2'b0, fh.start} + {1'b0, fh.len}) == {2'b0, off_reg});
    assign is_next = fh.valid && ({2'b0, fh.start} == ({2'b0, off_reg} + {1'b0, gs_reg}));
    assign merged = '{valid: 1'b1,
                      start: pf_reg ? ps_reg : off_reg,
                      len:   (pf_reg ? pl_reg : 17'd0) + gs_reg + (nf_reg ? nl_reg : 17'd0),
                      stamp: ic_reg};

    always_comb begin
        state_next = state_reg; cnt_next = cnt_reg;
        heap_next = heap_reg; align_next = align_reg;
        size_next = size_reg; off_next = off_reg;
        ic_next = ic_reg; used_next = used_reg;
        bf_next = bf_reg; bl_next = bl_reg; bs_next = bs_reg; bst_next = bst_reg;
        ins_next = ins_reg;
        pf_next = pf_reg; ps_next = ps_reg; pl_next = pl_reg;
        nf_next = nf_reg; nl_next = nl_reg; ef_next = ef_reg;
        gf_next = gf_reg; gs_next = gs_reg;
        rs_next = rs_reg; ro_next = ro_reg; rb_next = rb_reg;
        mv_next = mv_reg; md_next = md_reg;
        f_shift = 1'b0; g_shift = 1'b0; load_en = 1'b0;
        f_tail = fh; g_tail = gh;
        cand_bf = 1'b0;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD: begin
                load_en    = 1'b1;
                ic_next    = 32'd1;
                used_next  = 17'd0;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (cfg_valid) begin
                    if (cfg_index == REG_HEAP_BYTES) begin
                        heap_next = cfg_data;
                    end else if (cfg_index == REG_ALIGN_LOG2) begin
                        align_next = cfg_data[2:0];
                    end
                    if (cfg_index == REG_HEAP_BYTES || cfg_index == REG_ALIGN_LOG2) begin
                        state_next = S_LOAD;
                    end
                end else if (s_tvalid) begin
                    off_next = s_tdata[32:17];
                    size_next = req_round;
                    cnt_next = '0;
                    bf_next = 1'b0; ins_next = 1'b0; gf_next = 1'b0;
                    pf_next = 1'b0; nf_next = 1'b0; ef_next = 1'b0;
                    if (s_tuser == CMD_ALLOC) begin
                        if (s_tdata[16:0] == 17'd0) begin
                            rs_next = ST_ZERO_SIZE; ro_next = '0; rb_next = '0;
                            state_next = S_OUT;
                        end else begin
                            state_next = S_A_FSCAN;
                        end
                    end else begin
                        state_next = S_F_GFIND;
                    end
                end
            end
            S_A_FSCAN: begin
                f_shift = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                cand_bf = bf_reg;
                if (fh.valid && {1'b0, fh.len} >= size_reg &&
                    (!bf_reg || fh.len < bl_reg ||
                     (fh.len == bl_reg && fh.stamp < bs_reg))) begin
                    cand_bf = 1'b1;
                    bf_next = 1'b1; bl_next = fh.len; bs_next = fh.stamp;
                    bst_next = fh.start;
                end
                if (f_last) begin
                    cnt_next = '0;
                    if (!cand_bf) begin
                        rs_next = ST_NO_FIT; ro_next = '0; rb_next = '0;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_A_GINS;
                    end
                end
            end
            S_A_GINS: begin
                g_shift = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (!ins_reg && !gh.valid) begin
                    g_tail = '{valid: 1'b1, start: bst_reg, len: size_reg[16:0]};
                    ins_next = 1'b1;
                end
                if (g_last) begin
                    cnt_next = '0;
                    if (!ins_next) begin
                        rs_next = ST_FULL; ro_next = '0; rb_next = '0;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_A_FUPD;
                    end
                end
            end
            S_A_FUPD: begin
                f_shift = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (fh.valid && fh.start == bst_reg) begin
                    if ({1'b0, bl_reg} > size_reg) begin
                        f_tail = '{valid: 1'b1, start: fh.start + size_reg[15:0],
                                   len: fh.len - size_reg[16:0], stamp: ic_reg};
                        ic_next = ic_reg + 32'd1;
                    end else begin
                        f_tail.valid = 1'b0;
                    end
                end
                if (f_last) begin
                    cnt_next = '0;
                    used_next = used_reg + size_reg[16:0];
                    rs_next = ST_OK; ro_next = bst_reg; rb_next = size_reg[16:0];
                    state_next = S_OUT;
                end
            end
            S_F_GFIND: begin
                g_shift = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (gh.valid && gh.start == off_reg) begin
                    gf_next = 1'b1; gs_next = gh.len;
                end
                if (g_last) begin
                    cnt_next = '0;
                    if (!gf_next) begin
                        rs_next = ST_UNKNOWN; ro_next = '0; rb_next = '0;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_F_FSCAN;
                    end
                end
            end
            S_F_FSCAN: begin
                f_shift = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (is_prev) begin
                    pf_next = 1'b1; ps_next = fh.start; pl_next = fh.len;
                end
                if (is_next) begin
                    nf_next = 1'b1; nl_next = fh.len;
                end
                if (!fh.valid) begin
                    ef_next = 1'b1;
                end
                if (f_last) begin
                    cnt_next = '0;
                    if (!pf_next && !nf_next && !ef_next) begin
                        rs_next = ST_FULL; ro_next = '0; rb_next = '0;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_F_FUPD;
                    end
                end
            end
            S_F_FUPD: begin
                f_shift = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (is_prev) begin
                    f_tail = merged;
                end else if (is_next) begin
                    if (pf_reg) begin
                        f_tail.valid = 1'b0;
                    end else begin
                        f_tail = merged;
                    end
                end else if (!fh.valid && !pf_reg && !nf_reg && !ins_reg) begin
                    f_tail = merged;
                    ins_next = 1'b1;
                end
                if (f_last) begin
                    cnt_next = '0;
                    ic_next = ic_reg + 32'd1;
                    state_next = S_F_GDEL;
                end
            end
            S_F_GDEL: begin
                g_shift = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (gh.valid && gh.start == off_reg) begin
                    g_tail.valid = 1'b0;
                end
                if (g_last) begin
                    cnt_next = '0;
                    used_next = used_reg - gs_reg;
                    rs_next = ST_OK; ro_next = '0; rb_next = gs_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    md_next = {3'b0, used_reg, rb_reg, ro_reg, rs_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            heap_reg  <= 17'(HEAP_BYTES);
            align_reg <= 3'd2;
            ic_reg    <= 32'd1;
            used_reg  <= 17'd0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            heap_reg  <= heap_next;
            align_reg <= align_next;
            ic_reg    <= ic_next;
            used_reg  <= used_next;
            mv_reg    <= mv_next;
        end
        size_reg <= size_next; off_reg <= off_next;
        bf_reg <= bf_next; bl_reg <= bl_next; bs_reg <= bs_next; bst_reg <= bst_next;
        ins_reg <= ins_next;
        pf_reg <= pf_next; ps_reg <= ps_next; pl_reg <= pl_next;
        nf_reg <= nf_next; nl_reg <= nl_next; ef_reg <= ef_next;
        gf_reg <= gf_next; gs_reg <= gs_next;
        rs_reg <= rs_next; ro_reg <= ro_next; rb_reg <= rb_next;
        md_reg <= md_next;
    end

    genvar i;
    generate
        for (i = 0; i < FREE_ENTRIES; i++) begin : g_free
            if (i == FREE_ENTRIES - 1) begin : g_tail_f
                assign fd[i] = f_tail;
            end else begin : g_mid_f
                assign fd[i] = fq[i+1];
            end
            bfha_fcell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .load_en  (load_en),
                .load_val ((i == 0) ? f_init : free_cell_t'('0)),
                .shift_en (f_shift),
                .d        (fd[i]),
                .q        (fq[i])
            );
        end
        for (i = 0; i < GRANT_ENTRIES; i++) begin : g_grant
            if (i == GRANT_ENTRIES - 1) begin : g_tail_g
                assign gd[i] = g_tail;
            end else begin : g_mid_g
                assign gd[i] = gq[i+1];
            end
            bfha_gcell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .clear_en (load_en),
                .shift_en (g_shift),
                .d        (gd[i]),
                .q        (gq[i])
            );
        end
    endgenerate

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = md_reg;
endmodule
`default_nettype wire

### design/bfha_fcell.sv
// One cell of the rotating free-segment chain.
`default_nettype none
module bfha_fcell
    import bfha_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load_en,
    input  wire free_cell_t load_val,
    input  wire logic       shift_en,
    input  wire free_cell_t d,
    output free_cell_t      q
);
    free_cell_t q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else if (load_en) begin
            q_reg <= load_val;
        end else if (shift_en) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;
endmodule
`default_nettype wire

### design/bfha_gcell.sv
// One cell of the rotating grant chain.
`default_nettype none
module bfha_gcell
    import bfha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        clear_en,
    input  wire logic        shift_en,
    input  wire grant_cell_t d,
    output grant_cell_t      q
);
    grant_cell_t q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else if (clear_en) begin
            q_reg.valid <= 1'b0;
        end else if (shift_en) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;
endmodule
`default_nettype wire

### test/tb_best_fit_heap_allocator.sv
// Self-checking testbench for the best-fit heap allocator with random traffic and stalls.
`timescale 1ns / 1ps
module tb_best_fit_heap_allocator;
    import bfha_pkg::*;

    localparam logic CMD_FREE   = 1'b1;
    localparam int   WDOG_LIMIT = 5000;
    localparam int   SETTLE     = 300;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] offset;
        logic [16:0] bytes;
        logic [16:0] used;
    } alloc_result_t;

    typedef struct {
        bit            pause;
        logic          cmd;
        logic [16:0]   req;
        logic [15:0]   off;
        alloc_result_t res;
    } request_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    best_fit_heap_allocator dut (.*);

    // allocator shadow state
    int unsigned heap_cfg, align_cfg;
    int unsigned seg_start [FREE_ENTRIES];
    int unsigned seg_len   [FREE_ENTRIES];
    bit          seg_live  [FREE_ENTRIES];
    int unsigned seg_stamp [FREE_ENTRIES];
    int unsigned next_stamp;
    int unsigned blk_start [GRANT_ENTRIES];
    int unsigned blk_len   [GRANT_ENTRIES];
    bit          blk_live  [GRANT_ENTRIES];
    int unsigned bytes_in_use;

    request_t      pending_q [$];
    alloc_result_t grant_q [$];
    request_t      cur_req;
    int            errors;
    bit            quiet;
    int            s_gap, m_gap, idle_cycles;

    function automatic int unsigned align_mask();
        int unsigned lg;
        lg = (align_cfg >= 2 && align_cfg <= 5) ? align_cfg : 2;
        return (32'd1 << lg) - 1;
    endfunction

    function automatic void heap_rebuild();
        int unsigned sz;
        sz = heap_cfg > HEAP_BYTES ? HEAP_BYTES : heap_cfg;
        sz &= ~align_mask();
        for (int i = 0; i < FREE_ENTRIES; i++) begin
            seg_start[i] = 0; seg_len[i] = 0; seg_live[i] = 0; seg_stamp[i] = 0;
        end
        for (int i = 0; i < GRANT_ENTRIES; i++) begin
            blk_start[i] = 0; blk_len[i] = 0; blk_live[i] = 0;
        end
        next_stamp = 1;
        bytes_in_use = 0;
        if (sz != 0) begin
            seg_len[0] = sz;
            seg_live[0] = 1;
        end
    endfunction

    function automatic void seg_put(int slot, int unsigned st, int unsigned len);
        seg_start[slot] = st;
        seg_len[slot] = len;
        seg_live[slot] = 1;
        seg_stamp[slot] = next_stamp;
        next_stamp++;
    endfunction

    function automatic alloc_result_t make_res(logic [2:0] st, int unsigned o, int unsigned b);
        alloc_result_t r;
        r.status = st;
        r.offset = o[15:0];
        r.bytes  = b[16:0];
        r.used   = bytes_in_use[16:0];
        return r;
    endfunction

    function automatic alloc_result_t heap_step(logic cmd, int unsigned req, int unsigned off);
        int unsigned m, sz, st, ln, nst, nln;
        int best, gslot, g, prv, nxt, slot;
        best = -1; gslot = -1; g = -1; prv = -1; nxt = -1; slot = -1;
        if (cmd == CMD_ALLOC) begin
            m = align_mask();
            if (req == 0) return make_res(ST_ZERO_SIZE, 0, 0);
            sz = (req + m) & ~m;
            for (int i = 0; i < FREE_ENTRIES; i++) begin
                if (!seg_live[i] || seg_len[i] < sz) continue;
                if (best < 0 || seg_len[i] < seg_len[best] ||
                    (seg_len[i] == seg_len[best] && seg_stamp[i] < seg_stamp[best]))
                    best = i;
            end
            if (best < 0) return make_res(ST_NO_FIT, 0, 0);
            for (int i = 0; i < GRANT_ENTRIES; i++)
                if (!blk_live[i]) begin gslot = i; break; end
            if (gslot < 0) return make_res(ST_FULL, 0, 0);
            st = seg_start[best];
            ln = seg_len[best];
            seg_live[best] = 0;
            if (ln > sz) seg_put(best, st + sz, ln - sz);
            blk_start[gslot] = st;
            blk_len[gslot] = sz;
            blk_live[gslot] = 1;
            bytes_in_use += sz;
            return make_res(ST_OK, st, sz);
        end
        for (int i = 0; i < GRANT_ENTRIES; i++)
            if (blk_live[i] && blk_start[i] == off) begin g = i; break; end
        if (g < 0) return make_res(ST_UNKNOWN, 0, 0);
        sz = blk_len[g];
        for (int i = 0; i < FREE_ENTRIES; i++) begin
            if (!seg_live[i]) continue;
            if (seg_start[i] + seg_len[i] == off) prv = i;
            if (seg_start[i] == off + sz) nxt = i;
        end
        if (prv >= 0) slot = prv;
        else if (nxt >= 0) slot = nxt;
        else begin
            for (int i = 0; i < FREE_ENTRIES; i++)
                if (!seg_live[i]) begin slot = i; break; end
            if (slot < 0) return make_res(ST_FULL, 0, 0);
        end
        nst = prv >= 0 ? seg_start[prv] : off;
        nln = (prv >= 0 ? seg_len[prv] : 0) + sz + (nxt >= 0 ? seg_len[nxt] : 0);
        if (prv >= 0) seg_live[prv] = 0;
        if (nxt >= 0) seg_live[nxt] = 0;
        seg_put(slot, nst, nln);
        blk_live[g] = 0;
        bytes_in_use -= sz;
        return make_res(ST_OK, 0, sz);
    endfunction

    task automatic queue_request(logic cmd, int unsigned req, int unsigned off);
        request_t r;
        r.pause = 0;
        r.cmd = cmd;
        r.req = req[16:0];
        r.off = off[15:0];
        r.res = heap_step(cmd, r.req, r.off);
        pending_q.push_back(r);
    endtask

    task automatic queue_pause();
        request_t r;
        r = '{default: 0};
        r.pause = 1;
        pending_q.push_back(r);
    endtask

    task automatic queue_random(int alloc_pct, int max_size);
        int unsigned r, live_n, pick;
        int unsigned live_offs [$];
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            r = $urandom_range(0, 99);
            if (r < 4) queue_request(CMD_ALLOC, 0, $urandom);
            else if (r < 10) queue_request(CMD_ALLOC, $urandom_range(0, 131071), $urandom);
            else queue_request(CMD_ALLOC, $urandom_range(1, max_size), $urandom);
        end else begin
            for (int i = 0; i < GRANT_ENTRIES; i++)
                if (blk_live[i]) live_offs.push_back(blk_start[i]);
            live_n = live_offs.size();
            if (live_n != 0 && $urandom_range(0, 99) < 80) begin
                pick = $urandom_range(0, live_n - 1);
                queue_request(CMD_FREE, $urandom, live_offs[pick]);
            end else begin
                queue_request(CMD_FREE, $urandom, $urandom_range(0, 65535));
            end
        end
    endtask

    task automatic drain_all();
        wait (pending_q.size() == 0 && grant_q.size() == 0 && !s_tvalid);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        drain_all();
        cfg_index <= idx;
        cfg_data  <= val[16:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_HEAP_BYTES) heap_cfg = val & 32'h1FFFF;
        else align_cfg = val & 32'h7;
        heap_rebuild();
    endtask

    task automatic random_phase(int n, int alloc_pct, int max_size);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) queue_pause();
            queue_random(alloc_pct, max_size);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap <= 0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) grant_q.push_back(cur_req.res);
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() != 0 && pending_q[0].pause) begin
                s_tvalid <= 1'b0;
                if (grant_q.size() == 0 && !s_tvalid) void'(pending_q.pop_front());
            end else if (pending_q.size() != 0) begin
                cur_req = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_req.cmd;
                s_tdata  <= {7'b0, cur_req.off, cur_req.req};
                if (!quiet && $urandom_range(0, 7) == 0) s_gap <= $urandom_range(1, 12);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        alloc_result_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (grant_q.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    errors++;
                end else begin
                    e = grant_q.pop_front();
                    if (m_tdata[2:0] !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[18:3] !== e.offset) begin
                        $error("grant_offset: expected %0d, got %0d", e.offset, m_tdata[18:3]);
                        errors++;
                    end
                    if (m_tdata[35:19] !== e.bytes) begin
                        $error("grant_bytes: expected %0d, got %0d", e.bytes, m_tdata[35:19]);
                        errors++;
                    end
                    if (m_tdata[52:36] !== e.used) begin
                        $error("used_bytes: expected %0d, got %0d", e.used, m_tdata[52:36]);
                        errors++;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) m_gap <= $urandom_range(1, 12);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAIL best_fit_heap_allocator");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        errors = 0;
        quiet = 0;
        idle_cycles = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        heap_cfg  = HEAP_BYTES;
        align_cfg = 2;
        heap_rebuild();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        queue_request(CMD_ALLOC, 0, 0);
        queue_request(CMD_FREE, 0, 65535);
        queue_request(CMD_ALLOC, 1, 0);
        queue_request(CMD_ALLOC, 65536, 0);
        queue_request(CMD_ALLOC, 131071, 65535);
        queue_request(CMD_FREE, 0, 0);
        queue_request(CMD_ALLOC, 65536, 0);
        queue_request(CMD_ALLOC, 4, 0);
        queue_request(CMD_FREE, 131071, 0);
        queue_request(CMD_ALLOC, 5, 0);
        queue_request(CMD_ALLOC, 12, 0);
        queue_request(CMD_ALLOC, 8, 0);
        queue_request(CMD_ALLOC, 12, 0);
        queue_request(CMD_FREE, 0, 8);
        queue_request(CMD_FREE, 0, 28);
        queue_request(CMD_ALLOC, 8, 0);
        queue_request(CMD_FREE, 0, 0);
        queue_request(CMD_FREE, 0, 20);
        queue_request(CMD_FREE, 0, 8);
        queue_request(CMD_FREE, 0, 40);
        random_phase(250, 60, 4096);

        write_reg(REG_HEAP_BYTES, 260);
        for (int i = 0; i < 66; i++) queue_request(CMD_ALLOC, 4, 0);
        random_phase(200, 45, 16);

        write_reg(REG_HEAP_BYTES, 0);
        queue_request(CMD_ALLOC, 1, 0);
        queue_request(CMD_FREE, 0, 0);
        random_phase(20, 50, 64);

        write_reg(REG_ALIGN_LOG2, 5);
        write_reg(REG_HEAP_BYTES, 100000);
        queue_request(CMD_ALLOC, 65536, 0);
        queue_request(CMD_FREE, 0, 0);
        random_phase(300, 60, 2048);

        write_reg(REG_ALIGN_LOG2, 7);
        random_phase(250, 65, 512);

        write_reg(REG_ALIGN_LOG2, 3);
        write_reg(REG_HEAP_BYTES, 1001);
        random_phase(250, 55, 96);

        write_reg(REG_ALIGN_LOG2, 0);
        write_reg(REG_HEAP_BYTES, 65536);
        random_phase(300, 60, 8192);

        write_reg(REG_ALIGN_LOG2, 4);
        random_phase(300, 55, 1024);
        drain_all();
        quiet = 1;
        random_phase(150, 55, 1024);
        drain_all();

        if (errors == 0) begin
            $display("PASS best_fit_heap_allocator");
        end else begin
            $display("FAIL best_fit_heap_allocator");
        end
        $finish;
    end
endmodule

### sim.f
design/bfha_pkg.sv
design/bfha_fcell.sv
design/bfha_gcell.sv
design/best_fit_heap_allocator.sv
test/tb_best_fit_heap_allocator.sv
